/* sv/bhts_pkg.sv */
package bhts_pkg;

    localparam int DEF_HISTORY_DEPTH = 64;

    localparam int ERR_W  = 16;
    localparam int LOAD_W = 7;
    localparam int LAT_W  = 24;
    localparam int TOT_W  = 32;
    localparam int HELD_W = 7;

    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;

    localparam int ROOT_IN_W = 2 * LAT_W;

    typedef struct packed {
        logic capture;
        logic fetch;
        logic sub;
        logic add;
        logic mean_start;
        logic mean_sq;
        logic nm;
        logic var_start;
        logic root_start;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic root_done;
        logic out_free;
    } t_status;

endpackage

/* sv/bhts_ram.sv */
module bhts_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 64,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/bhts_div.sv */
module bhts_div #(
    parameter int NUM_W = 54,
    parameter int DEN_W = 7,
    localparam int STEP_W = $clog2(NUM_W + 1)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [NUM_W-1:0]  i_num,
    input  logic [DEN_W-1:0]  i_den,
    input  logic [STEP_W-1:0] i_steps,
    output logic [NUM_W-1:0]  o_quo,
    output logic              o_done
);

    logic [NUM_W-1:0]  r_quo;
    logic [DEN_W-1:0]  r_rem;
    logic [STEP_W-1:0] r_left;
    logic              r_done;
    logic [DEN_W:0]    shifted;
    logic [DEN_W:0]    diff;
    logic              fits;

    assign shifted = {r_rem, r_quo[NUM_W-1]};
    assign fits    = shifted >= {1'b0, i_den};
    assign diff    = shifted - {1'b0, i_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_left <= i_steps;
            end else if (r_left != '0) begin
                r_left <= r_left - 1'b1;
                if (r_left == STEP_W'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_num;
            r_rem <= '0;
        end else if (r_left != '0) begin
            r_quo <= {r_quo[NUM_W-2:0], fits};
            r_rem <= fits ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
        end
    end

    assign o_quo  = r_quo;
    assign o_done = r_done;

endmodule

/* sv/bhts_sqrt.sv */
module bhts_sqrt #(
    parameter int W = 48,
    localparam int HW = W / 2,
    localparam int RW = HW + 2,
    localparam int STEP_W = $clog2(HW + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [W-1:0]  i_val,
    output logic [HW-1:0] o_root,
    output logic          o_done
);

    logic [W-1:0]      r_val;
    logic [RW-1:0]     r_rem;
    logic [HW-1:0]     r_root;
    logic [STEP_W-1:0] r_left;
    logic              r_done;
    logic [RW-1:0]     shifted;
    logic [RW-1:0]     trial;
    logic              fits;

    assign shifted = {r_rem[RW-3:0], r_val[W-1 -: 2]};
    assign trial   = {r_root, 2'b01};
    assign fits    = shifted >= trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_left <= STEP_W'(HW);
            end else if (r_left != '0) begin
                r_left <= r_left - 1'b1;
                if (r_left == STEP_W'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_val  <= i_val;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_left != '0) begin
            r_val  <= {r_val[W-3:0], 2'b00};
            r_rem  <= fits ? (shifted - trial) : shifted;
            r_root <= {r_root[HW-2:0], fits};
        end
    end

    assign o_root = r_root;
    assign o_done = r_done;

endmodule

/* sv/bhts_ctrl.sv */
module bhts_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  bhts_pkg::t_status i_status,
    output bhts_pkg::t_cmd    o_cmd
);
    import bhts_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_FETCH  = 4'd1;
    localparam logic [3:0] S_SUB    = 4'd2;
    localparam logic [3:0] S_ADD    = 4'd3;
    localparam logic [3:0] S_MSTART = 4'd4;
    localparam logic [3:0] S_MWAIT  = 4'd5;
    localparam logic [3:0] S_MSQ    = 4'd6;
    localparam logic [3:0] S_NM     = 4'd7;
    localparam logic [3:0] S_VSTART = 4'd8;
    localparam logic [3:0] S_VWAIT  = 4'd9;
    localparam logic [3:0] S_RWAIT  = 4'd10;
    localparam logic [3:0] S_OUT    = 4'd11;

    logic [3:0] r_state;
    logic [3:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_FETCH;
                end
            end
            S_FETCH: begin
                o_cmd.fetch = 1'b1;
                n_state     = S_SUB;
            end
            S_SUB: begin
                o_cmd.sub = 1'b1;
                n_state   = S_ADD;
            end
            S_ADD: begin
                o_cmd.add = 1'b1;
                n_state   = S_MSTART;
            end
            S_MSTART: begin
                o_cmd.mean_start = 1'b1;
                n_state          = S_MWAIT;
            end
            S_MWAIT: begin
                if (i_status.div_done) begin
                    n_state = S_MSQ;
                end
            end
            S_MSQ: begin
                o_cmd.mean_sq = 1'b1;
                n_state       = S_NM;
            end
            S_NM: begin
                o_cmd.nm = 1'b1;
                n_state  = S_VSTART;
            end
            S_VSTART: begin
                o_cmd.var_start = 1'b1;
                n_state         = S_VWAIT;
            end
            S_VWAIT: begin
                if (i_status.div_done) begin
                    o_cmd.root_start = 1'b1;
                    n_state          = S_RWAIT;
                end
            end
            S_RWAIT: begin
                if (i_status.root_done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

/* sv/bhts_dp.sv */
module bhts_dp #(
    parameter int HISTORY_DEPTH = bhts_pkg::DEF_HISTORY_DEPTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  bhts_pkg::t_cmd                    i_cmd,
    output bhts_pkg::t_status                 o_status,
    input  logic [bhts_pkg::ERR_W-1:0]        i_tx_error_count,
    input  logic [bhts_pkg::ERR_W-1:0]        i_rx_error_count,
    input  logic [bhts_pkg::LOAD_W-1:0]       i_bus_load_percent,
    input  logic [bhts_pkg::LAT_W-1:0]        i_worst_latency_us,
    input  logic [bhts_pkg::TOT_W-1:0]        i_retransmit_total,
    input  logic [bhts_pkg::TOT_W-1:0]        i_collision_total,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [bhts_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [bhts_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [bhts_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic                              o_abnormal,
    output logic [bhts_pkg::HELD_W-1:0]       o_samples_held,
    output logic [bhts_pkg::LAT_W-1:0]        o_latency_mean,
    output logic [bhts_pkg::LAT_W-1:0]        o_latency_deviation
);
    import bhts_pkg::*;

    localparam int L       = $clog2(HISTORY_DEPTH);
    localparam int CW      = $clog2(HISTORY_DEPTH + 1);
    localparam int SW      = LAT_W + L;
    localparam int QW      = 2 * LAT_W + L;
    localparam int DSTEP_W = $clog2(QW + 1);
    localparam int PW      = 2 * LAT_W;

    localparam logic [2:0] REG_TX_LIMIT    = 3'd0;
    localparam logic [2:0] REG_RX_LIMIT    = 3'd1;
    localparam logic [2:0] REG_LOAD_LIMIT  = 3'd2;
    localparam logic [2:0] REG_LAT_LIMIT   = 3'd3;
    localparam logic [2:0] REG_RETX_LIMIT  = 3'd4;
    localparam logic [2:0] REG_COLL_LIMIT  = 3'd5;

    localparam logic [ERR_W-1:0]  RST_TX_LIMIT   = ERR_W'(10);
    localparam logic [ERR_W-1:0]  RST_RX_LIMIT   = ERR_W'(10);
    localparam logic [LOAD_W-1:0] RST_LOAD_LIMIT = LOAD_W'(80);
    localparam logic [LAT_W-1:0]  RST_LAT_LIMIT  = LAT_W'(5000);
    localparam logic [TOT_W-1:0]  RST_RETX_LIMIT = TOT_W'(5);
    localparam logic [TOT_W-1:0]  RST_COLL_LIMIT = TOT_W'(5);

    logic [ERR_W-1:0]  r_tx_limit;
    logic [ERR_W-1:0]  r_rx_limit;
    logic [LOAD_W-1:0] r_load_limit;
    logic [LAT_W-1:0]  r_lat_limit;
    logic [TOT_W-1:0]  r_retx_limit;
    logic [TOT_W-1:0]  r_coll_limit;
    logic [2:0]        reg_idx;
    logic              cfg_write;

    logic [L-1:0]      r_slot;
    logic [CW-1:0]     r_cnt;
    logic [SW-1:0]     r_sum;
    logic [QW-1:0]     r_sq;
    logic [LAT_W-1:0]  r_lat;
    logic              r_abn;
    logic [LAT_W-1:0]  r_old;
    logic [PW-1:0]     r_prod;
    logic [QW-1:0]     r_nm;
    logic [LAT_W-1:0]  r_mean;
    logic              full;
    logic [LAT_W-1:0]  rdata;
    logic [LAT_W-1:0]  old_val;
    logic [LAT_W-1:0]  mul_a;
    logic [PW+CW-1:0]  nm_full;

    logic               div_start;
    logic [QW-1:0]      div_num;
    logic [DSTEP_W-1:0] div_steps;
    logic [QW-1:0]      div_quo;
    logic               div_done;
    logic [LAT_W-1:0]   root;
    logic               root_done;

    logic              r_out_valid;
    logic              r_out_abn;
    logic [HELD_W-1:0] r_out_held;
    logic [LAT_W-1:0]  r_out_mean;
    logic [LAT_W-1:0]  r_out_dev;

    assign reg_idx   = paddr[4:2];
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tx_limit   <= RST_TX_LIMIT;
            r_rx_limit   <= RST_RX_LIMIT;
            r_load_limit <= RST_LOAD_LIMIT;
            r_lat_limit  <= RST_LAT_LIMIT;
            r_retx_limit <= RST_RETX_LIMIT;
            r_coll_limit <= RST_COLL_LIMIT;
        end else if (cfg_write) begin
            case (reg_idx)
                REG_TX_LIMIT:   r_tx_limit   <= pwdata[ERR_W-1:0];
                REG_RX_LIMIT:   r_rx_limit   <= pwdata[ERR_W-1:0];
                REG_LOAD_LIMIT: r_load_limit <= pwdata[LOAD_W-1:0];
                REG_LAT_LIMIT:  r_lat_limit  <= pwdata[LAT_W-1:0];
                REG_RETX_LIMIT: r_retx_limit <= pwdata[TOT_W-1:0];
                REG_COLL_LIMIT: r_coll_limit <= pwdata[TOT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_TX_LIMIT:   prdata = APB_DATA_W'(r_tx_limit);
            REG_RX_LIMIT:   prdata = APB_DATA_W'(r_rx_limit);
            REG_LOAD_LIMIT: prdata = APB_DATA_W'(r_load_limit);
            REG_LAT_LIMIT:  prdata = APB_DATA_W'(r_lat_limit);
            REG_RETX_LIMIT: prdata = APB_DATA_W'(r_retx_limit);
            REG_COLL_LIMIT: prdata = APB_DATA_W'(r_coll_limit);
            default:        prdata = '0;
        endcase
    end

    // The ring fills in slot order, so the slot about to be written holds an old sample only once the ring is full.
    assign full    = (r_cnt == CW'(HISTORY_DEPTH));
    assign old_val = full ? rdata : '0;

    bhts_ram #(
        .WIDTH (LAT_W),
        .DEPTH (HISTORY_DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (i_cmd.sub),
        .i_waddr (r_slot),
        .i_wdata (r_lat),
        .i_re    (i_cmd.capture),
        .i_raddr (r_slot),
        .o_rdata (rdata)
    );

    always_comb begin
        if (i_cmd.fetch) begin
            mul_a = old_val;
        end else if (i_cmd.sub) begin
            mul_a = r_lat;
        end else begin
            mul_a = div_quo[LAT_W-1:0];
        end
    end

    assign nm_full = (PW + CW)'(r_prod) * (PW + CW)'(r_cnt);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot <= '0;
            r_cnt  <= '0;
            r_sum  <= '0;
            r_sq   <= '0;
        end else if (i_cmd.sub) begin
            r_sum <= r_sum - SW'(r_old);
            r_sq  <= r_sq - QW'(r_prod);
        end else if (i_cmd.add) begin
            r_sum  <= r_sum + SW'(r_lat);
            r_sq   <= r_sq + QW'(r_prod);
            r_slot <= (r_slot == L'(HISTORY_DEPTH - 1)) ? '0 : r_slot + 1'b1;
            if (!full) begin
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_lat <= i_worst_latency_us;
            r_abn <= (i_tx_error_count > r_tx_limit) || (i_rx_error_count > r_rx_limit)
                  || (i_bus_load_percent > r_load_limit)
                  || (i_worst_latency_us > r_lat_limit)
                  || (i_retransmit_total > r_retx_limit)
                  || (i_collision_total > r_coll_limit);
        end
        if (i_cmd.fetch) begin
            r_old <= old_val;
        end
        if (i_cmd.fetch || i_cmd.sub || i_cmd.mean_sq) begin
            r_prod <= PW'(mul_a) * PW'(mul_a);
        end
        if (i_cmd.mean_sq) begin
            r_mean <= div_quo[LAT_W-1:0];
        end
        if (i_cmd.nm) begin
            r_nm <= nm_full[QW-1:0];
        end
    end

    assign div_start = i_cmd.mean_start || i_cmd.var_start;
    assign div_num   = i_cmd.mean_start ? {r_sum, {LAT_W{1'b0}}} : (r_sq - r_nm);
    assign div_steps = i_cmd.mean_start ? DSTEP_W'(SW) : DSTEP_W'(QW);

    bhts_div #(
        .NUM_W (QW),
        .DEN_W (CW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (r_cnt),
        .i_steps (div_steps),
        .o_quo   (div_quo),
        .o_done  (div_done)
    );

    bhts_sqrt #(
        .W (ROOT_IN_W)
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.root_start),
        .i_val   (div_quo[ROOT_IN_W-1:0]),
        .o_root  (root),
        .o_done  (root_done)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_abn  <= r_abn;
            r_out_held <= HELD_W'(r_cnt);
            r_out_mean <= r_mean;
            r_out_dev  <= root;
        end
    end

    assign o_status.div_done  = div_done;
    assign o_status.root_done = root_done;
    assign o_status.out_free  = !r_out_valid || i_out_ready;

    assign o_out_valid         = r_out_valid;
    assign o_abnormal          = r_out_abn;
    assign o_samples_held      = r_out_held;
    assign o_latency_mean      = r_out_mean;
    assign o_latency_deviation = r_out_dev;

endmodule

/* sv/bus_health_threshold_window_stats_core.sv */
// Channel   Handshake                 Payload
// input     i_in_valid / o_in_ready   six bus-health metrics of one sample
// output    o_out_valid / i_out_ready abnormal flag, samples held, mean, deviation
// config    APB write/read            six limit registers at byte address 4*index
//
// The time from one accepted transfer to the next is set by the shared bit-serial divider,
// used once for the mean and once for the variance, and by the square root unit that
// resolves one result bit a cycle.
// A new sample is accepted once the previous one has been handed to the output register.
// Reset is synchronous and active low; it clears the history and restores the limits.
// A stalled output transfer holds the result and keeps the next sample from finishing.
module bus_health_threshold_window_stats_core #(
    parameter int HISTORY_DEPTH = bhts_pkg::DEF_HISTORY_DEPTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [bhts_pkg::ERR_W-1:0]      i_tx_error_count,
    input  logic [bhts_pkg::ERR_W-1:0]      i_rx_error_count,
    input  logic [bhts_pkg::LOAD_W-1:0]     i_bus_load_percent,
    input  logic [bhts_pkg::LAT_W-1:0]      i_worst_latency_us,
    input  logic [bhts_pkg::TOT_W-1:0]      i_retransmit_total,
    input  logic [bhts_pkg::TOT_W-1:0]      i_collision_total,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic                            o_abnormal,
    output logic [bhts_pkg::HELD_W-1:0]     o_samples_held,
    output logic [bhts_pkg::LAT_W-1:0]      o_latency_mean,
    output logic [bhts_pkg::LAT_W-1:0]      o_latency_deviation,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [bhts_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [bhts_pkg::APB_DATA_W-1:0] pwdata,
    output logic [bhts_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready
);
    import bhts_pkg::*;

    t_cmd    cmd;
    t_status status;

    assign pready = 1'b1;

    bhts_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    bhts_dp #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (cmd),
        .o_status            (status),
        .i_tx_error_count    (i_tx_error_count),
        .i_rx_error_count    (i_rx_error_count),
        .i_bus_load_percent  (i_bus_load_percent),
        .i_worst_latency_us  (i_worst_latency_us),
        .i_retransmit_total  (i_retransmit_total),
        .i_collision_total   (i_collision_total),
        .psel                (psel),
        .penable             (penable),
        .pwrite              (pwrite),
        .paddr               (paddr),
        .pwdata              (pwdata),
        .prdata              (prdata),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_abnormal          (o_abnormal),
        .o_samples_held      (o_samples_held),
        .o_latency_mean      (o_latency_mean),
        .o_latency_deviation (o_latency_deviation)
    );

endmodule

/* sv/bhts_chk.sv */
module bhts_chk (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_in_valid,
    input logic                            o_in_ready,
    input logic                            o_out_valid,
    input logic                            i_out_ready,
    input logic                            o_abnormal,
    input logic [bhts_pkg::HELD_W-1:0]     o_samples_held,
    input logic [bhts_pkg::LAT_W-1:0]      o_latency_mean,
    input logic [bhts_pkg::LAT_W-1:0]      o_latency_deviation
);
    import bhts_pkg::*;

    // Only one sample is in work at a time.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input accepted again while a sample is in work");

    // A result is produced only at the end of a sample's work.
    a_result_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> !$past(o_in_ready))
        else $error("result appeared without a sample in work");

    // The spread of values within the latency range is at most half that range.
    a_dev_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !o_latency_deviation[LAT_W-1])
        else $error("deviation exceeds half the latency range");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_abnormal)
            && $stable(o_samples_held) && $stable(o_latency_mean)
            && $stable(o_latency_deviation)))
        else $error("stalled output transfer changed");

endmodule

bind bus_health_threshold_window_stats_core bhts_chk u_chk (.*);

/* dv/bus_health_threshold_window_stats_core_test.sv */
`timescale 1ns / 1ps

module bus_health_threshold_window_stats_core_test;
    import bhts_pkg::*;

    localparam int DEPTH       = DEF_HISTORY_DEPTH;
    localparam int CYCLE_LIMIT = 1_000_000;

    typedef enum logic [2:0] {
        LIM_TX_ERR,
        LIM_RX_ERR,
        LIM_BUS_LOAD,
        LIM_LATENCY,
        LIM_RETRANSMIT,
        LIM_COLLISION,
        SPARE_6,
        SPARE_7
    } limit_reg_e;

    typedef struct {
        logic [ERR_W-1:0]  tx_err;
        logic [ERR_W-1:0]  rx_err;
        logic [LOAD_W-1:0] load;
        logic [LAT_W-1:0]  latency;
        logic [TOT_W-1:0]  retrans;
        logic [TOT_W-1:0]  collis;
    } sample_t;

    typedef struct {
        logic              abnormal;
        logic [HELD_W-1:0] held;
        logic [LAT_W-1:0]  mean;
        logic [LAT_W-1:0]  dev;
    } stats_t;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    logic [ERR_W-1:0]      i_tx_error_count = '0;
    logic [ERR_W-1:0]      i_rx_error_count = '0;
    logic [LOAD_W-1:0]     i_bus_load_percent = '0;
    logic [LAT_W-1:0]      i_worst_latency_us = '0;
    logic [TOT_W-1:0]      i_retransmit_total = '0;
    logic [TOT_W-1:0]      i_collision_total = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    logic                  o_abnormal;
    logic [HELD_W-1:0]     o_samples_held;
    logic [LAT_W-1:0]      o_latency_mean;
    logic [LAT_W-1:0]      o_latency_deviation;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    bus_health_threshold_window_stats_core dut (.*);

    logic [31:0]      limits [6] = '{32'd10, 32'd10, 32'd80, 32'd5000, 32'd5, 32'd5};
    logic [LAT_W-1:0] lat_hist [DEPTH];
    bit               hist_valid [DEPTH];
    int               hist_slot = 0;
    int               hist_count = 0;
    logic [63:0]      hist_sum = '0;
    logic [63:0]      hist_sq_sum = '0;

    sample_t sample_queue [$];
    stats_t  expected_stats [$];
    int      items_pushed = 0;
    int      items_accepted = 0;
    int      failures = 0;
    int      cycle_count = 0;
    bit      sample_taken = 1'b0;
    int      in_gap = 0;
    int      in_quiet = 0;
    int      out_hold = 0;
    int      out_quiet = 0;

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    function automatic logic [31:0] field_mask(input limit_reg_e r);
        case (r)
            LIM_TX_ERR, LIM_RX_ERR:       return 32'h0000_FFFF;
            LIM_BUS_LOAD:                 return 32'h0000_007F;
            LIM_LATENCY:                  return 32'h00FF_FFFF;
            LIM_RETRANSMIT, LIM_COLLISION: return 32'hFFFF_FFFF;
            default:                      return 32'h0;
        endcase
    endfunction

    function automatic stats_t predict_stats(input sample_t s);
        stats_t      r;
        logic [63:0] lat;
        logic [63:0] old;
        logic [63:0] n;
        logic [63:0] mean;
        logic [63:0] v;
        logic [63:0] root;
        logic [63:0] trial;
        lat = 64'(s.latency);
        r.abnormal = (s.tx_err > limits[LIM_TX_ERR]) || (s.rx_err > limits[LIM_RX_ERR])
                  || (s.load > limits[LIM_BUS_LOAD]) || (lat > limits[LIM_LATENCY])
                  || (s.retrans > limits[LIM_RETRANSMIT])
                  || (s.collis > limits[LIM_COLLISION]);
        if (hist_valid[hist_slot]) begin
            old = 64'(lat_hist[hist_slot]);
            hist_sum = hist_sum - old;
            hist_sq_sum = hist_sq_sum - old * old;
        end else begin
            hist_valid[hist_slot] = 1'b1;
            hist_count++;
        end
        lat_hist[hist_slot] = s.latency;
        hist_sum = hist_sum + lat;
        hist_sq_sum = hist_sq_sum + lat * lat;
        hist_slot = (hist_slot + 1) % DEPTH;
        n = 64'(hist_count);
        mean = hist_sum / n;
        v = (hist_sq_sum - n * mean * mean) / n;
        root = '0;
        for (int b = LAT_W - 1; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= v) begin
                root = trial;
            end
        end
        r.held = HELD_W'(hist_count);
        r.mean = LAT_W'(mean);
        r.dev  = LAT_W'(root);
        return r;
    endfunction

    function automatic int pick_gap(inout int quiet);
        int r;
        if (quiet > 0) begin
            quiet--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3) begin
            quiet = $urandom_range(20, 80);
            return 0;
        end
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 15);
        return $urandom_range(30, 150);
    endfunction

    function automatic logic [31:0] pick_metric(input limit_reg_e r, input bit healthy);
        logic [31:0] lim;
        logic [31:0] fmax;
        int          k;
        lim = limits[r];
        fmax = field_mask(r);
        k = $urandom_range(0, 9);
        if (healthy) begin
            return (k < 2) ? lim : $urandom_range(lim, 0);
        end
        case (k)
            0, 1, 2: return (lim < fmax) ? lim + 1 : lim;
            3, 4, 5: return $urandom & fmax;
            6:       return fmax;
            default: return $urandom_range(lim, 0);
        endcase
    endfunction

    function automatic sample_t make_sample(input logic [31:0] tx, input logic [31:0] rx,
                                            input logic [31:0] load, input logic [31:0] lat,
                                            input logic [31:0] re, input logic [31:0] co);
        sample_t s;
        s.tx_err  = ERR_W'(tx);
        s.rx_err  = ERR_W'(rx);
        s.load    = LOAD_W'(load);
        s.latency = LAT_W'(lat);
        s.retrans = re;
        s.collis  = co;
        return s;
    endfunction

    function automatic sample_t random_sample();
        bit healthy;
        healthy = ($urandom_range(0, 1) == 0);
        return make_sample(pick_metric(LIM_TX_ERR, healthy), pick_metric(LIM_RX_ERR, healthy),
                           pick_metric(LIM_BUS_LOAD, healthy), pick_metric(LIM_LATENCY, healthy),
                           pick_metric(LIM_RETRANSMIT, healthy),
                           pick_metric(LIM_COLLISION, healthy));
    endfunction

    task automatic queue_sample(input sample_t s);
        sample_queue.push_back(s);
        items_pushed++;
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            failures++;
        end
    endtask

    task automatic apb_xfer(input bit is_write, input logic [APB_ADDR_W-1:0] addr,
                            input logic [31:0] wdata, output logic [31:0] rdata);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= addr;
        pwdata  <= wdata;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        rdata = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_limit(input limit_reg_e r, input logic [31:0] v);
        logic [31:0] unused;
        apb_xfer(1'b1, {r, 2'b00}, v, unused);
        if (r <= LIM_COLLISION) begin
            limits[r] = v & field_mask(r);
        end
    endtask

    task automatic wait_idle();
        do @(negedge i_clk);
        while (items_accepted != items_pushed || expected_stats.size() != 0);
    endtask

    always @(negedge i_clk) begin : feed_samples
        sample_t s;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (i_in_valid && !sample_taken) begin
            i_in_valid <= 1'b1;
        end else if (in_gap > 0) begin
            i_in_valid <= 1'b0;
            in_gap--;
        end else if (sample_queue.size() > 0) begin
            s = sample_queue.pop_front();
            i_tx_error_count   <= s.tx_err;
            i_rx_error_count   <= s.rx_err;
            i_bus_load_percent <= s.load;
            i_worst_latency_us <= s.latency;
            i_retransmit_total <= s.retrans;
            i_collision_total  <= s.collis;
            i_in_valid         <= 1'b1;
            in_gap = pick_gap(in_quiet);
        end else begin
            i_in_valid <= 1'b0;
        end
    end

    always @(negedge i_clk) begin : drain_results
        if (out_hold > 0) begin
            i_out_ready <= 1'b0;
            out_hold--;
        end else begin
            i_out_ready <= 1'b1;
            out_hold = pick_gap(out_quiet);
        end
    end

    always @(posedge i_clk) begin : watch_ports
        sample_t taken;
        stats_t  want;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("bus_health_threshold_window_stats_core_test NOT OK");
            $finish;
        end else if (!i_rst_n) begin
            sample_taken <= 1'b0;
        end else begin
            sample_taken <= i_in_valid && o_in_ready;
            if (i_in_valid && o_in_ready) begin
                taken = make_sample(32'(i_tx_error_count), 32'(i_rx_error_count),
                                    32'(i_bus_load_percent), 32'(i_worst_latency_us),
                                    i_retransmit_total, i_collision_total);
                expected_stats.push_back(predict_stats(taken));
                items_accepted++;
            end
            if (o_out_valid && i_out_ready) begin
                if (expected_stats.size() == 0) begin
                    $error("result transfer with no sample outstanding");
                    failures++;
                end else begin
                    want = expected_stats.pop_front();
                    check_field("abnormal", 32'(want.abnormal), 32'(o_abnormal));
                    check_field("samples_held", 32'(want.held), 32'(o_samples_held));
                    check_field("latency_mean", 32'(want.mean), 32'(o_latency_mean));
                    check_field("latency_deviation", 32'(want.dev), 32'(o_latency_deviation));
                end
            end
        end
    end

    initial begin : stimulus
        logic [31:0] rd;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                1: begin
                    for (int r = 0; r < 6; r++) set_limit(limit_reg_e'(r), 32'h0);
                    set_limit(SPARE_6, 32'hFFFF_FFFF);
                    set_limit(SPARE_7, 32'hFFFF_FFFF);
                end
                2: begin
                    for (int r = 0; r < 6; r++) set_limit(limit_reg_e'(r), 32'hFFFF_FFFF);
                end
                3: begin
                    for (int r = 0; r < 6; r++) set_limit(limit_reg_e'(r), $urandom);
                end
                4: begin
                    set_limit(LIM_TX_ERR, $urandom_range(0, 200));
                    set_limit(LIM_RX_ERR, $urandom_range(0, 200));
                    set_limit(LIM_BUS_LOAD, $urandom_range(0, 100));
                    set_limit(LIM_LATENCY, $urandom_range(0, 100000));
                    set_limit(LIM_RETRANSMIT, $urandom_range(0, 1000));
                    set_limit(LIM_COLLISION, $urandom_range(0, 1000));
                end
                default: ;
            endcase
            for (int r = 0; r < 6; r++) begin
                apb_xfer(1'b0, {r[2:0], 2'b00}, 32'h0, rd);
                check_field("limit readback", limits[r], rd);
            end
            if (phase == 0) begin
                queue_sample(make_sample(0, 0, 0, 0, 0, 0));
                queue_sample(make_sample(10, 10, 80, 5000, 5, 5));
                queue_sample(make_sample(11, 10, 80, 5000, 5, 5));
                queue_sample(make_sample(10, 11, 80, 5000, 5, 5));
                queue_sample(make_sample(10, 10, 81, 5000, 5, 5));
                queue_sample(make_sample(10, 10, 80, 5001, 5, 5));
                queue_sample(make_sample(10, 10, 80, 5000, 6, 5));
                queue_sample(make_sample(10, 10, 80, 5000, 5, 6));
                queue_sample(make_sample(32'hFFFF, 32'hFFFF, 127, 32'hFF_FFFF,
                                         32'hFFFF_FFFF, 32'hFFFF_FFFF));
                queue_sample(make_sample(0, 0, 101, 0, 0, 0));
                queue_sample(make_sample(0, 0, 127, 0, 0, 0));
                queue_sample(make_sample(0, 0, 100, 32'hFF_FFFF, 0, 0));
                queue_sample(make_sample(0, 0, 0, 32'hFF_FFFF, 0, 0));
                queue_sample(make_sample(1, 1, 1, 1, 1, 1));
                queue_sample(make_sample(0, 0, 0, 32'h80_0000, 0, 0));
                queue_sample(make_sample(0, 0, 0, 32'h7F_FFFF, 0, 0));
                queue_sample(make_sample(32'hAAAA, 32'h5555, 32'h55, 32'hAA_AAAA,
                                         32'hAAAA_AAAA, 32'h5555_5555));
                queue_sample(make_sample(32'h5555, 32'hAAAA, 32'h2A, 32'h55_5555,
                                         32'h5555_5555, 32'hAAAA_AAAA));
            end
            repeat ((phase == 0) ? 90 : (phase == 3) ? 120 : 110) begin
                queue_sample(random_sample());
            end
            wait_idle();
        end
        repeat (150) @(posedge i_clk);
        if (failures == 0) begin
            $display("bus_health_threshold_window_stats_core_test OK");
        end else begin
            $display("bus_health_threshold_window_stats_core_test NOT OK");
        end
        $finish;
    end

endmodule
